// ===== sv/hrb_pkg.sv =====
// ============================================================================
// hrb_pkg: shared definitions for the host request balancer
// Constants, command and register codes, and the sequencer state type.
// ============================================================================
`default_nettype none

package hrb_pkg;

   // Number of classes carried by the channel fields, and the class limit.
   localparam int FIELD_CLASSES = 8;
   localparam int MAX_ARCHES    = 8;
   localparam int CLASS_LIMIT   = (MAX_ARCHES < FIELD_CLASSES) ? MAX_ARCHES : FIELD_CLASSES;

   // Widths of the datapath.
   localparam int CLS_W  = 3;    // class index
   localparam int CNT_W  = 4;    // class count, 1..8
   localparam int WRK_W  = 16;   // workers and outstanding counts
   localparam int LOAD_W = 18;   // workers plus outstanding plus grants
   localparam int SUM_W  = 19;   // total workers
   localparam int TOT_W  = 20;   // total workers plus outstanding
   localparam int ASK_W  = 7;    // per-class request
   localparam int CSR_W  = 16;   // widest register
   localparam int IDX_W  = 1;    // register index

   // Request increments.
   localparam logic [WRK_W-1:0] HOST_INC  = 16'd6;
   localparam logic [ASK_W-1:0] ASK_HALF  = 7'd6;
   localparam logic [ASK_W-1:0] ASK_FULL  = 7'd12;
   localparam logic [WRK_W-1:0] OUT_MAX   = 16'hFFFF;
   localparam logic [CNT_W-1:0] CLASS_LIM = CNT_W'(CLASS_LIMIT);

   // Command codes.
   localparam logic CMD_ARRIVE = 1'b0;
   localparam logic CMD_EVAL   = 1'b1;

   // Register indexes.
   localparam logic [IDX_W-1:0] REG_TARGET     = 1'd0;
   localparam logic [IDX_W-1:0] REG_ARCH_COUNT = 1'd1;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_DECIDE,
      ST_SCAN,
      ST_GRANT,
      ST_UPDATE,
      ST_DONE
   } hrb_state_type;

endpackage

`default_nettype wire

// ===== sv/hrb_req_if.sv =====
// ============================================================================
// hrb_req_if: input request channel
// Valid/ready channel carrying a command, a class and per-class worker counts.
// ============================================================================
`default_nettype none

interface hrb_req_if
   import hrb_pkg::*;
();
   logic             valid;
   logic             ready;
   logic             cmd;
   logic [CLS_W-1:0] arch;
   logic [WRK_W-1:0] workers_0;
   logic [WRK_W-1:0] workers_1;
   logic [WRK_W-1:0] workers_2;
   logic [WRK_W-1:0] workers_3;
   logic [WRK_W-1:0] workers_4;
   logic [WRK_W-1:0] workers_5;
   logic [WRK_W-1:0] workers_6;
   logic [WRK_W-1:0] workers_7;

   modport source (
      output valid, cmd, arch,
             workers_0, workers_1, workers_2, workers_3,
             workers_4, workers_5, workers_6, workers_7,
      input  ready
   );

   modport sink (
      input  valid, cmd, arch,
             workers_0, workers_1, workers_2, workers_3,
             workers_4, workers_5, workers_6, workers_7,
      output ready
   );
endinterface

`default_nettype wire

// ===== sv/hrb_rsp_if.sv =====
// ============================================================================
// hrb_rsp_if: result channel
// Valid/ready channel carrying the surplus and the per-class host requests.
// ============================================================================
`default_nettype none

interface hrb_rsp_if
   import hrb_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [SUM_W-1:0] surplus_workers;
   logic [ASK_W-1:0] request_0;
   logic [ASK_W-1:0] request_1;
   logic [ASK_W-1:0] request_2;
   logic [ASK_W-1:0] request_3;
   logic [ASK_W-1:0] request_4;
   logic [ASK_W-1:0] request_5;
   logic [ASK_W-1:0] request_6;
   logic [ASK_W-1:0] request_7;

   modport source (
      output valid, surplus_workers,
             request_0, request_1, request_2, request_3,
             request_4, request_5, request_6, request_7,
      input  ready
   );

   modport sink (
      input  valid, surplus_workers,
             request_0, request_1, request_2, request_3,
             request_4, request_5, request_6, request_7,
      output ready
   );
endinterface

`default_nettype wire

// ===== sv/host_request_balancer.sv =====
// ============================================================================
// host_request_balancer: per-class host request planner
// Tracks outstanding host requests per class and plans new requests.
// ============================================================================
//
//   channel   direction  contents
//   req_ch    in         cmd, arch, workers_0..workers_7
//   rsp_ch    out        surplus_workers, request_0..request_7
//   csr_*     in         write enable, register index, write data
//
// An arrival request is accepted in idle and gives no result. An evaluate
// request is accepted, then the classes in use are accumulated one by one,
// a decision is made, and during rebalancing each unit handed out (up to 95
// units) takes a serial argmin scan over the classes in use; the outstanding
// counts are then updated unless workers plus outstanding equal the target or
// the workers alone exceed it, and finally the output register is loaded.
// Reset is synchronous; the outstanding counts clear at once, no sweep.
// A result waiting in the output register does not hold off the next request,
// but an evaluate that finishes behind it stalls, not ready, until it is taken.
// ============================================================================
`default_nettype none

module host_request_balancer
   import hrb_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   hrb_req_if.sink               req_ch,
   hrb_rsp_if.source             rsp_ch,
   input  wire logic             csr_we,
   input  wire logic [IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0] csr_wdata
);

   // Control and state registers.
   hrb_state_type    state_ff, state_in;
   logic [WRK_W-1:0] target_ff, target_in;
   logic [CNT_W-1:0] arch_count_ff, arch_count_in;
   logic [WRK_W-1:0] out_ff [FIELD_CLASSES];
   logic [WRK_W-1:0] out_in [FIELD_CLASSES];
   logic             rsp_valid_ff, rsp_valid_in;

   // Datapath registers.
   logic [WRK_W-1:0]  w_ff    [FIELD_CLASSES];
   logic [WRK_W-1:0]  w_in    [FIELD_CLASSES];
   logic [LOAD_W-1:0] load_ff [FIELD_CLASSES];
   logic [LOAD_W-1:0] load_in [FIELD_CLASSES];
   logic [ASK_W-1:0]  ask_ff  [FIELD_CLASSES];
   logic [ASK_W-1:0]  ask_in  [FIELD_CLASSES];
   logic [ASK_W-1:0]  rq_ff   [FIELD_CLASSES];
   logic [ASK_W-1:0]  rq_in   [FIELD_CLASSES];
   logic [CLS_W-1:0]  idx_ff, idx_in;
   logic [CLS_W-1:0]  best_ff, best_in;
   logic [LOAD_W-1:0] best_load_ff, best_load_in;
   logic [SUM_W-1:0]  tw_ff, tw_in;
   logic [TOT_W-1:0]  twr_ff, twr_in;
   logic [ASK_W-1:0]  th_ff, th_in;
   logic [ASK_W-1:0]  desired_ff, desired_in;
   logic [SUM_W-1:0]  surplus_ff, surplus_in;
   logic [SUM_W-1:0]  sq_ff, sq_in;

   // Combinational helpers.
   logic [CNT_W-1:0]  n_eff;
   logic              last_idx;
   logic [CLS_W-1:0]  out_sel;
   logic [CLS_W-1:0]  load_sel;
   logic [WRK_W-1:0]  out_rd;
   logic [WRK_W-1:0]  w_rd;
   logic [LOAD_W-1:0] load_rd;
   logic [WRK_W:0]    pair_sum;
   logic [ASK_W-1:0]  ask_plan;
   logic [TOT_W:0]    plan_total;
   logic [TOT_W-1:0]  short_fall;
   logic [WRK_W:0]    upd_sum [FIELD_CLASSES];
   logic              rsp_free;

   // Effective class count: zero acts as one, large values saturate.
   always_comb begin
      if (arch_count_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (arch_count_ff > CLASS_LIM) begin
         n_eff = CLASS_LIM;
      end else begin
         n_eff = arch_count_ff;
      end
   end

   // Shared read ports on the class arrays.
   assign last_idx   = ({1'b0, idx_ff} == (n_eff - CNT_W'(1)));
   assign out_sel    = (state_ff == ST_IDLE) ? req_ch.arch : idx_ff;
   assign load_sel   = (state_ff == ST_GRANT) ? best_ff : idx_ff;
   assign out_rd     = out_ff[out_sel];
   assign w_rd       = w_ff[idx_ff];
   assign load_rd    = load_ff[load_sel];
   assign pair_sum   = {1'b0, w_rd} + {1'b0, out_rd};
   assign plan_total = {1'b0, twr_ff} + {{(TOT_W + 1 - ASK_W){1'b0}}, th_ff};
   assign short_fall = {{(TOT_W - WRK_W){1'b0}}, target_ff} - twr_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_ch.ready;

   // Planned request of the class under the accumulator.
   always_comb begin
      if (out_rd < HOST_INC) begin
         ask_plan = ASK_FULL;
      end else if (out_rd == HOST_INC) begin
         ask_plan = ASK_HALF;
      end else begin
         ask_plan = '0;
      end
   end

   // Saturating update sums of the outstanding counts.
   always_comb begin
      for (int i = 0; i < FIELD_CLASSES; i++) begin
         upd_sum[i] = {1'b0, out_ff[i]} + {{(WRK_W + 1 - ASK_W){1'b0}}, ask_ff[i]};
      end
   end

   // Sequencer: next state and datapath updates.
   always_comb begin
      state_in      = state_ff;
      target_in     = target_ff;
      arch_count_in = arch_count_ff;
      out_in        = out_ff;
      w_in          = w_ff;
      load_in       = load_ff;
      ask_in        = ask_ff;
      rq_in         = rq_ff;
      idx_in        = idx_ff;
      best_in       = best_ff;
      best_load_in  = best_load_ff;
      tw_in         = tw_ff;
      twr_in        = twr_ff;
      th_in         = th_ff;
      desired_in    = desired_ff;
      surplus_in    = surplus_ff;
      sq_in         = sq_ff;
      req_ch.ready  = 1'b0;

      // A waiting result leaves once it is taken.
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;

      // Configuration writes.
      if (csr_we) begin
         case (csr_index)
            REG_TARGET: begin
               target_in = csr_wdata;
            end
            REG_ARCH_COUNT: begin
               arch_count_in = csr_wdata[CNT_W-1:0];
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               if (req_ch.cmd == CMD_ARRIVE) begin
                  // An arrival retires one outstanding request of its class.
                  if (({1'b0, req_ch.arch} < n_eff) && (out_rd != '0)) begin
                     out_in[req_ch.arch] = out_rd - WRK_W'(1);
                  end
               end else begin
                  w_in[0] = req_ch.workers_0;
                  w_in[1] = req_ch.workers_1;
                  w_in[2] = req_ch.workers_2;
                  w_in[3] = req_ch.workers_3;
                  w_in[4] = req_ch.workers_4;
                  w_in[5] = req_ch.workers_5;
                  w_in[6] = req_ch.workers_6;
                  w_in[7] = req_ch.workers_7;
                  for (int i = 0; i < FIELD_CLASSES; i++) begin
                     ask_in[i] = '0;
                  end
                  tw_in      = '0;
                  twr_in     = '0;
                  th_in      = '0;
                  surplus_in = '0;
                  idx_in     = '0;
                  state_in   = ST_ACCUM;
               end
            end
         end

         ST_ACCUM: begin
            // One class per cycle: totals, planned request and load.
            load_in[idx_ff] = {{(LOAD_W - WRK_W - 1){1'b0}}, pair_sum};
            tw_in           = tw_ff + {{(SUM_W - WRK_W){1'b0}}, w_rd};
            twr_in          = twr_ff + {{(TOT_W - WRK_W - 1){1'b0}}, pair_sum};
            ask_in[idx_ff]  = ask_plan;
            th_in           = th_ff + ask_plan;
            if (last_idx) begin
               state_in = ST_DECIDE;
            end else begin
               idx_in = idx_ff + CLS_W'(1);
            end
         end

         ST_DECIDE: begin
            if (twr_ff == {{(TOT_W - WRK_W){1'b0}}, target_ff}) begin
               // At target: nothing requested, no update.
               for (int i = 0; i < FIELD_CLASSES; i++) begin
                  ask_in[i] = '0;
               end
               state_in = ST_DONE;
            end else if (tw_ff > {{(SUM_W - WRK_W){1'b0}}, target_ff}) begin
               // Above target: report the surplus only.
               for (int i = 0; i < FIELD_CLASSES; i++) begin
                  ask_in[i] = '0;
               end
               surplus_in = tw_ff - {{(SUM_W - WRK_W){1'b0}}, target_ff};
               state_in   = ST_DONE;
            end else if ((th_ff != '0) &&
                         ({{(TOT_W + 1 - WRK_W){1'b0}}, target_ff} < plan_total)) begin
               // The plan overshoots: hand out the shortfall instead.
               for (int i = 0; i < FIELD_CLASSES; i++) begin
                  ask_in[i] = '0;
               end
               if (twr_ff < {{(TOT_W - WRK_W){1'b0}}, target_ff}) begin
                  desired_in = short_fall[ASK_W-1:0];
                  idx_in     = '0;
                  state_in   = ST_SCAN;
               end else begin
                  desired_in = '0;
                  state_in   = ST_UPDATE;
               end
            end else begin
               state_in = ST_UPDATE;
            end
         end

         ST_SCAN: begin
            // Serial argmin over the loads, lowest index wins ties.
            if ((idx_ff == '0) || (load_rd < best_load_ff)) begin
               best_in      = idx_ff;
               best_load_in = load_rd;
            end
            if (last_idx) begin
               state_in = ST_GRANT;
            end else begin
               idx_in = idx_ff + CLS_W'(1);
            end
         end

         ST_GRANT: begin
            // Give one unit to the least loaded class.
            load_in[best_ff] = load_rd + LOAD_W'(1);
            ask_in[best_ff]  = ask_ff[best_ff] + ASK_W'(1);
            desired_in       = desired_ff - ASK_W'(1);
            idx_in           = '0;
            if (desired_ff == ASK_W'(1)) begin
               state_in = ST_UPDATE;
            end else begin
               state_in = ST_SCAN;
            end
         end

         ST_UPDATE: begin
            // Requests are taken as granted; counts saturate.
            for (int i = 0; i < FIELD_CLASSES; i++) begin
               if (upd_sum[i][WRK_W]) begin
                  out_in[i] = OUT_MAX;
               end else begin
                  out_in[i] = upd_sum[i][WRK_W-1:0];
               end
            end
            state_in = ST_DONE;
         end

         ST_DONE: begin
            // Load the output register once it is free.
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               sq_in        = surplus_ff;
               rq_in        = ask_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         target_ff     <= '0;
         arch_count_ff <= CNT_W'(1);
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < FIELD_CLASSES; i++) begin
            out_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         target_ff     <= target_in;
         arch_count_ff <= arch_count_in;
         rsp_valid_ff  <= rsp_valid_in;
         out_ff        <= out_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      w_ff         <= w_in;
      load_ff      <= load_in;
      ask_ff       <= ask_in;
      rq_ff        <= rq_in;
      idx_ff       <= idx_in;
      best_ff      <= best_in;
      best_load_ff <= best_load_in;
      tw_ff        <= tw_in;
      twr_ff       <= twr_in;
      th_ff        <= th_in;
      desired_ff   <= desired_in;
      surplus_ff   <= surplus_in;
      sq_ff        <= sq_in;
   end

   // Result channel.
   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.surplus_workers = sq_ff;
   assign rsp_ch.request_0       = rq_ff[0];
   assign rsp_ch.request_1       = rq_ff[1];
   assign rsp_ch.request_2       = rq_ff[2];
   assign rsp_ch.request_3       = rq_ff[3];
   assign rsp_ch.request_4       = rq_ff[4];
   assign rsp_ch.request_5       = rq_ff[5];
   assign rsp_ch.request_6       = rq_ff[6];
   assign rsp_ch.request_7       = rq_ff[7];

endmodule

`default_nettype wire
